/* rtl/pitc_pkg.sv */
// Package for the tapered capsule point test.
// Holds default widths, reset constants and configuration register indexes.
// No dependencies.
package pitc_pkg;

  localparam int CoordWidthDef = 24;
  localparam int AxisWidthDef  = 16;
  localparam int CfgIdxW       = 3;
  localparam int HalfQ8        = 128;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX   = 3'd0,
    CfgCenterY   = 3'd1,
    CfgCenterZ   = 3'd2,
    CfgAxisRight = 3'd3,
    CfgAxisUp    = 3'd4,
    CfgAxisView  = 3'd5,
    CfgHalfH     = 3'd6,
    CfgRadii     = 3'd7
  } cfg_idx_e;

endpackage

/* rtl/point_in_tapered_capsule.sv */
// Tapered capsule point test: world point to local frame, clamp, radius lerp, distance compare.
// Depends on pitc_pkg.
// Throughput one transaction per cycle; busy stays low, results cannot be stalled.
// The radius divide is a pipelined restoring divider, one quotient bit per stage.
// Reset clears valid bits and loads the identity axes, zero center, 0.5 half height and radii.
// Configuration writes take effect at once and must happen while the pipeline is empty.
module point_in_tapered_capsule #(
  parameter int COORD_WIDTH = pitc_pkg::CoordWidthDef,
  parameter int AXIS_WIDTH  = pitc_pkg::AxisWidthDef,
  localparam int CfgW = (3 * AXIS_WIDTH > 2 * COORD_WIDTH - 1) ? 3 * AXIS_WIDTH
                                                                : 2 * COORD_WIDTH - 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          done_o,
  output logic                          inside_res_o,
  input  logic                          cfg_we_i,
  input  logic [pitc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]               cfg_wdata_i
);

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = AXIS_WIDTH;
  localparam int F   = AW - 2;
  localparam int DW  = CW + 1;
  localparam int PW  = DW + AW;
  localparam int SW  = PW + 2;
  localparam int LW  = SW - F;
  localparam int MW  = CW + 4;
  localparam int QW  = CW;
  localparam int NW  = 2 * CW;
  localparam int DSW = 2 * MW + 2;
  localparam int Lat = QW + 9;

  localparam logic [AW-1:0] AxisOne = AW'(1) << F;

  // configuration registers
  logic [CW-1:0]   cx_q, cy_q, cz_q;
  logic [3*AW-1:0] ar_q, au_q, av_q;
  logic [CW-2:0]   hh_q;
  logic [2*CW-2:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      ar_q  <= {{(2*AW){1'b0}}, AxisOne};
      au_q  <= {{AW{1'b0}}, AxisOne, {AW{1'b0}}};
      av_q  <= {AxisOne, {(2*AW){1'b0}}};
      hh_q  <= (CW-1)'(pitc_pkg::HalfQ8);
      rad_q <= {(CW-1)'(pitc_pkg::HalfQ8), CW'(pitc_pkg::HalfQ8)};
    end else if (cfg_we_i) begin
      case (pitc_pkg::cfg_idx_e'(cfg_idx_i))
        pitc_pkg::CfgCenterX:   cx_q  <= cfg_wdata_i[CW-1:0];
        pitc_pkg::CfgCenterY:   cy_q  <= cfg_wdata_i[CW-1:0];
        pitc_pkg::CfgCenterZ:   cz_q  <= cfg_wdata_i[CW-1:0];
        pitc_pkg::CfgAxisRight: ar_q  <= cfg_wdata_i[3*AW-1:0];
        pitc_pkg::CfgAxisUp:    au_q  <= cfg_wdata_i[3*AW-1:0];
        pitc_pkg::CfgAxisView:  av_q  <= cfg_wdata_i[3*AW-1:0];
        pitc_pkg::CfgHalfH:     hh_q  <= cfg_wdata_i[CW-2:0];
        pitc_pkg::CfgRadii:     rad_q <= cfg_wdata_i[2*CW-2:0];
        default: ;
      endcase
    end
  end

  // derived configuration terms
  logic [CW-1:0] rb, rt, diff, dvs;
  logic          up, h0;

  assign rb   = rad_q[CW-1:0];
  assign rt   = CW'(rad_q[2*CW-2:CW]);
  assign up   = (rt >= rb);
  assign diff = up ? (rt - rb) : (rb - rt);
  assign h0   = (hh_q == '0);
  assign dvs  = {hh_q, 1'b0};

  assign busy = 1'b0;

  // stage 1: offset from center
  logic signed [DW-1:0] d_q [3];
  logic                 v1_q;

  always_ff @(posedge clk_i) begin
    d_q[0] <= DW'(point_x_i) - DW'($signed(cx_q));
    d_q[1] <= DW'(point_y_i) - DW'($signed(cy_q));
    d_q[2] <= DW'(point_z_i) - DW'($signed(cz_q));
  end

  // stage 2: nine axis products
  logic [3*AW-1:0]      axr [3];
  logic signed [PW-1:0] prod_d [9];
  logic signed [PW-1:0] prod_q [9];
  logic                 v2_q;

  assign axr[0] = ar_q;
  assign axr[1] = au_q;
  assign axr[2] = av_q;

  always_comb begin
    logic signed [AW-1:0] a;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        a = $signed(axr[r][k*AW +: AW]);
        prod_d[3*r+k] = PW'(a) * PW'(d_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // stage 3: dot products, floor shift to Q.8
  logic signed [LW-1:0] loc_d [3];
  logic signed [LW-1:0] loc_q [3];
  logic                 v3_q;

  always_comb begin
    logic signed [SW-1:0] s;
    for (int r = 0; r < 3; r++) begin
      s = SW'(prod_q[3*r]) + SW'(prod_q[3*r+1]) + SW'(prod_q[3*r+2]);
      loc_d[r] = LW'(s >>> F);
    end
  end

  always_ff @(posedge clk_i) begin
    loc_q <= loc_d;
  end

  // stage 4: clamp, axis offset, magnitudes
  logic signed [LW-1:0] hsx, yc, ay, tsum;
  logic [MW-1:0]        mx_d, my_d, mz_d, mx_q, my_q, mz_q;
  logic [CW-1:0]        t_q;
  logic                 v4_q;

  assign hsx = LW'(hh_q);

  always_comb begin
    if (h0) begin
      yc = '0;
    end else if (loc_q[1] < -hsx) begin
      yc = -hsx;
    end else if (loc_q[1] > hsx) begin
      yc = hsx;
    end else begin
      yc = loc_q[1];
    end
    ay   = loc_q[1] - yc;
    tsum = yc + hsx;
    mx_d = loc_q[0][LW-1] ? MW'(-loc_q[0]) : MW'(loc_q[0]);
    my_d = ay[LW-1] ? MW'(-ay) : MW'(ay);
    mz_d = loc_q[2][LW-1] ? MW'(-loc_q[2]) : MW'(loc_q[2]);
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;
    my_q <= my_d;
    mz_q <= mz_d;
    t_q  <= tsum[CW-1:0];
  end

  // stage 5: squares and lerp numerator
  logic [2*MW-1:0] sx_q, sy_q, sz_q;
  logic [NW-1:0]   n_q;
  logic            v5_q;

  always_ff @(posedge clk_i) begin
    sx_q <= (2*MW)'(mx_q) * (2*MW)'(mx_q);
    sy_q <= (2*MW)'(my_q) * (2*MW)'(my_q);
    sz_q <= (2*MW)'(mz_q) * (2*MW)'(mz_q);
    n_q  <= NW'(diff) * NW'(t_q);
  end

  // stage 6 and divider: squared distance travels alongside the quotient
  logic [NW-1:0]  rem_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic [DSW-1:0] dst_q [QW+1];
  logic [QW:0]    dvv_q;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= n_q;
    quo_q[0] <= '0;
    dst_q[0] <= DSW'(sx_q) + DSW'(sy_q) + DSW'(sz_q);
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [NW-1:0] sub;
    logic          take;

    assign sub  = NW'(dvs) << B;
    assign take = (rem_q[j] >= sub);

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= take ? (rem_q[j] - sub) : rem_q[j];
      quo_q[j+1] <= quo_q[j] | (QW'(take) << B);
      dst_q[j+1] <= dst_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[j+1] <= 1'b0;
      end else begin
        dvv_q[j+1] <= dvv_q[j];
      end
    end
  end

  // radius, its square, compare
  logic [CW-1:0]   r_q;
  logic [DSW-1:0]  dr_q, ds_q;
  logic [2*CW-1:0] rsq_q;
  logic            vr_q, vs_q, done_q, inside_q;

  always_ff @(posedge clk_i) begin
    if (h0) begin
      r_q <= rt;
    end else if (up) begin
      r_q <= rb + quo_q[QW];
    end else begin
      r_q <= rb - quo_q[QW];
    end
    dr_q  <= dst_q[QW];
    rsq_q <= (2*CW)'(r_q) * (2*CW)'(r_q);
    ds_q  <= dr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      dvv_q[0] <= 1'b0;
      vr_q     <= 1'b0;
      vs_q     <= 1'b0;
      done_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      v1_q     <= start && !busy;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      dvv_q[0] <= v5_q;
      vr_q     <= dvv_q[QW];
      vs_q     <= vr_q;
      done_q   <= vs_q;
      inside_q <= vs_q && (ds_q <= DSW'(rsq_q));
    end
  end

  assign done_o       = done_q;
  assign inside_res_o = inside_q;

`ifndef SYNTH
  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Lat) done_o)
    else $error("transaction did not complete after the pipeline latency");

  a_quo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dvv_q[QW] && !h0) |-> (quo_q[QW] <= diff))
    else $error("radius step exceeds the radius difference");

  a_rad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs_q |-> ($past(r_q) >= (up ? rb : rt) && $past(r_q) <= (up ? rt : rb)))
    else $error("interpolated radius outside the two end radii");

  a_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_res_o |-> done_o)
    else $error("inside flag raised without a result strobe");
`endif

endmodule

/* tb/sv/point_in_tapered_capsule_tb.sv */
// Self-checking testbench for point_in_tapered_capsule: directed and random point queries
// against an in-bench predictor of the capsule test. Depends on pitc_pkg and the block RTL.
module point_in_tapered_capsule_tb;

  localparam int CW        = pitc_pkg::CoordWidthDef;
  localparam int AW        = pitc_pkg::AxisWidthDef;
  localparam int FRAC      = AW - 2;
  localparam int CFGW      = (3 * AW > 2 * CW - 1) ? 3 * AW : 2 * CW - 1;
  localparam int ONE_AXIS  = 1 << FRAC;
  localparam int IDLE_LIM  = 2000;
  localparam int TAIL_WAIT = CW + 20;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [3*AW-1:0] axis_row_t;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  coord_t           point_x_i   = '0;
  coord_t           point_y_i   = '0;
  coord_t           point_z_i   = '0;
  logic             done_o;
  logic             inside_res_o;
  logic             cfg_we_i    = 1'b0;
  logic [pitc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CFGW-1:0]  cfg_wdata_i = '0;

  coord_t           cfg_cx          = '0;
  coord_t           cfg_cy          = '0;
  coord_t           cfg_cz          = '0;
  axis_row_t        cfg_axis_right  = axis_row_t'(ONE_AXIS);
  axis_row_t        cfg_axis_up     = axis_row_t'(ONE_AXIS) << AW;
  axis_row_t        cfg_axis_view   = axis_row_t'(ONE_AXIS) << (2 * AW);
  logic [CW-2:0]    cfg_h           = (CW-1)'(pitc_pkg::HalfQ8);
  logic [2*CW-2:0]  cfg_radii       = {(CW-1)'(pitc_pkg::HalfQ8), CW'(pitc_pkg::HalfQ8)};

  bit               inside_expected_q[$];
  bit               inside_want;
  bit               gaps_on         = 1'b0;
  int               fail_count      = 0;
  int               points_sent     = 0;
  int               inside_seen     = 0;
  int               settings_used   = 0;
  int               idle_count      = 0;

  point_in_tapered_capsule u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .point_x_i,
    .point_y_i,
    .point_z_i,
    .done_o,
    .inside_res_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint to_local(axis_row_t row, longint dx, longint dy, longint dz);
    return (longint'($signed(row[AW-1:0])) * dx +
            longint'($signed(row[2*AW-1:AW])) * dy +
            longint'($signed(row[3*AW-1:2*AW])) * dz) >>> FRAC;
  endfunction

  function automatic bit predict_inside(coord_t px, coord_t py, coord_t pz);
    longint dx, dy, dz, lx, ly, lz, hs, yc;
    longint unsigned rb, rt, rad, diff, step, ax, ay, az;
    logic [127:0] dist2;
    dx = longint'(px) - longint'(cfg_cx);
    dy = longint'(py) - longint'(cfg_cy);
    dz = longint'(pz) - longint'(cfg_cz);
    lx = to_local(cfg_axis_right, dx, dy, dz);
    ly = to_local(cfg_axis_up, dx, dy, dz);
    lz = to_local(cfg_axis_view, dx, dy, dz);
    hs = longint'(cfg_h);
    rb = cfg_radii[CW-1:0];
    rt = cfg_radii[2*CW-2:CW];
    if (hs == 0) begin
      yc  = 0;
      rad = rt;
    end else begin
      yc   = (ly < -hs) ? -hs : ((ly > hs) ? hs : ly);
      diff = (rt >= rb) ? rt - rb : rb - rt;
      step = diff * longint'(yc + hs) / longint'(2 * hs);
      rad  = (rt >= rb) ? rb + step : rb - step;
    end
    ax = (lx < 0) ? -lx : lx;
    ay = (ly - yc < 0) ? yc - ly : ly - yc;
    az = (lz < 0) ? -lz : lz;
    dist2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
    return dist2 <= 128'(rad) * 128'(rad);
  endfunction

  function automatic int unsigned rand_bits(int k);
    return (k <= 0) ? 0 : ($urandom() & ((32'd1 << k) - 1));
  endfunction

  function automatic axis_row_t axis_row(int pos, bit neg);
    axis_row_t row;
    row = '0;
    row[pos*AW +: AW] = neg ? -AW'(ONE_AXIS) : AW'(ONE_AXIS);
    return row;
  endfunction

  function automatic axis_row_t rand_row();
    return {AW'($urandom_range(0, 2 * ONE_AXIS) - ONE_AXIS),
            AW'($urandom_range(0, 2 * ONE_AXIS) - ONE_AXIS),
            AW'($urandom_range(0, 2 * ONE_AXIS) - ONE_AXIS)};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        inside_expected_q.push_back(predict_inside(point_x_i, point_y_i, point_z_i));
        points_sent++;
      end
      if (done_o) begin
        if (inside_expected_q.size() == 0) begin
          $error("inside_res: no transaction pending, actual %0b", inside_res_o);
          fail_count++;
        end else begin
          inside_want = inside_expected_q.pop_front();
          if (inside_res_o !== inside_want) begin
            $error("inside_res: expected %0b, actual %0b", inside_want, inside_res_o);
            fail_count++;
          end
          if (inside_res_o === 1'b1) inside_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIM) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic send_point(int x, int y, int z);
    @(negedge clk_i);
    start     <= 1'b1;
    point_x_i <= CW'(x);
    point_y_i <= CW'(y);
    point_z_i <= CW'(z);
    do @(posedge clk_i); while (busy);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 4));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (inside_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(pitc_pkg::cfg_idx_e idx, logic [CFGW-1:0] data);
    @(negedge clk_i);
    start       <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      pitc_pkg::CfgCenterX:   cfg_cx = data[CW-1:0];
      pitc_pkg::CfgCenterY:   cfg_cy = data[CW-1:0];
      pitc_pkg::CfgCenterZ:   cfg_cz = data[CW-1:0];
      pitc_pkg::CfgAxisRight: cfg_axis_right = data[3*AW-1:0];
      pitc_pkg::CfgAxisUp:    cfg_axis_up = data[3*AW-1:0];
      pitc_pkg::CfgAxisView:  cfg_axis_view = data[3*AW-1:0];
      pitc_pkg::CfgHalfH:     cfg_h = data[CW-2:0];
      pitc_pkg::CfgRadii:     cfg_radii = data[2*CW-2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure_capsule(int cx, int cy, int cz, axis_row_t ar, axis_row_t au,
                                   axis_row_t av, int unsigned hh, int unsigned rb,
                                   int unsigned rt);
    drain_results();
    write_cfg(pitc_pkg::CfgCenterX, CFGW'(cx));
    write_cfg(pitc_pkg::CfgCenterY, CFGW'(cy));
    write_cfg(pitc_pkg::CfgCenterZ, CFGW'(cz));
    write_cfg(pitc_pkg::CfgAxisRight, CFGW'(ar));
    write_cfg(pitc_pkg::CfgAxisUp, CFGW'(au));
    write_cfg(pitc_pkg::CfgAxisView, CFGW'(av));
    write_cfg(pitc_pkg::CfgHalfH, CFGW'(hh));
    write_cfg(pitc_pkg::CfgRadii, CFGW'({(CW-1)'(rt), CW'(rb)}));
    settings_used++;
  endtask

  task automatic test_reset_capsule();
    settings_used++;
    send_point(0, 0, 0);
    send_point(0, 256, 0);
    send_point(0, 257, 0);
    send_point(128, 0, 0);
    send_point(0, -128, -129);
    send_point(8388607, 8388607, 8388607);
    send_point(-8388608, -8388608, -8388608);
    send_point(-8388608, 8388607, 0);
    drain_results();
  endtask

  task automatic test_tapered_capsule();
    configure_capsule(256, -512, 1024, axis_row(0, 0), axis_row(1, 0), axis_row(2, 0),
                      1024, 256, 768);
    send_point(256 + 256, -512 - 1024, 1024);
    send_point(256 + 257, -512 - 1024, 1024);
    send_point(256 + 768, -512 + 1024, 1024);
    send_point(256, -512 + 1024 + 768, 1024 + 1);
    send_point(256, -512, 1024 + 512);
    drain_results();
    write_cfg(pitc_pkg::CfgRadii, CFGW'({(CW-1)'(256), CW'(768)}));
    send_point(256 + 768, -512 - 1024, 1024);
    send_point(256 + 512, -512, 1024);
    send_point(256, -512 - 1024 - 769, 1024);
    drain_results();
  endtask

  task automatic test_zero_height_sphere();
    configure_capsule(0, 0, 0, axis_row(0, 0), axis_row(1, 0), axis_row(2, 0),
                      0, 24'hFFFFFF, 512);
    send_point(512, 0, 0);
    send_point(0, 513, 0);
    send_point(300, 300, 300);
    send_point(0, 0, -512);
    drain_results();
  endtask

  task automatic test_extreme_settings();
    configure_capsule(-8388608, -8388608, -8388608, {3{AW'(1) << (AW-1)}},
                      {3{~(AW'(1) << (AW-1))}}, {AW'(1) << (AW-1), ~(AW'(1) << (AW-1)), AW'(0)},
                      23'h7FFFFF, 24'hFFFFFF, 23'h7FFFFF);
    send_point(8388607, 8388607, 8388607);
    send_point(-8388608, -8388608, -8388608);
    send_point(8388607, -8388608, 0);
    configure_capsule(8388607, 8388607, 8388607, axis_row(0, 1), axis_row(1, 1),
                      axis_row(2, 1), 1, 0, 0);
    send_point(8388607, 8388607, 8388607);
    send_point(8388607, 8388606, 8388607);
    send_point(-8388608, 0, 8388607);
    drain_results();
  endtask

  task automatic test_random_capsules(int phases, int per_phase);
    int cx, cy, cz, span, hold_at, perm;
    int unsigned hh, rb, rt;
    axis_row_t ar, au, av;
    for (int p = 0; p < phases; p++) begin
      cx = $urandom_range(0, 1) ? int'(rand_bits($urandom_range(0, 24))) : $urandom();
      cy = $urandom_range(0, 1) ? -int'(rand_bits($urandom_range(0, 23))) : $urandom();
      cz = $urandom_range(0, 3) ? int'(rand_bits($urandom_range(0, 22))) : $urandom();
      case ($urandom_range(0, 3))
        0: begin
          ar = axis_row(0, 0);
          au = axis_row(1, 0);
          av = axis_row(2, 0);
        end
        1: begin
          perm = $urandom_range(0, 2);
          ar = axis_row(perm, 1'($urandom_range(0, 1)));
          au = axis_row((perm + 1) % 3, 1'($urandom_range(0, 1)));
          av = axis_row((perm + 2) % 3, 1'($urandom_range(0, 1)));
        end
        2: begin
          ar = rand_row();
          au = rand_row();
          av = rand_row();
        end
        default: begin
          ar = axis_row_t'({$urandom(), $urandom()});
          au = axis_row_t'({$urandom(), $urandom()});
          av = axis_row_t'({$urandom(), $urandom()});
        end
      endcase
      case ($urandom_range(0, 7))
        0: hh = 0;
        1: hh = 23'h7FFFFF;
        2: hh = 1;
        default: hh = rand_bits($urandom_range(1, 23));
      endcase
      rb = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : rand_bits($urandom_range(0, 24));
      rt = ($urandom_range(0, 9) == 0) ? 23'h7FFFFF : rand_bits($urandom_range(0, 23));
      configure_capsule(cx, cy, cz, ar, au, av, hh, rb, rt);
      span = int'((rb > rt) ? rb : rt) + int'(hh) + 16;
      gaps_on = (p < phases - 2) && ($urandom_range(0, 2) != 0);
      hold_at = (p == 0) ? per_phase / 2 : $urandom_range(0, 3 * per_phase);
      for (int i = 0; i < per_phase; i++) begin
        if (i == hold_at) drain_results();
        if ($urandom_range(0, 4) == 0) begin
          send_point($urandom(), $urandom(), $urandom());
        end else begin
          send_point(cx + int'($urandom_range(0, 2 * span)) - span,
                     cy + int'($urandom_range(0, 2 * span)) - span,
                     cz + int'($urandom_range(0, 2 * span)) - span);
        end
      end
    end
    gaps_on = 1'b0;
    drain_results();
  endtask

  initial begin
    bit left_want;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_capsule();
    test_tapered_capsule();
    test_zero_height_sphere();
    test_extreme_settings();
    test_random_capsules(14, 125);
    repeat (TAIL_WAIT) @(posedge clk_i);
    while (inside_expected_q.size() != 0) begin
      left_want = inside_expected_q.pop_front();
      $error("inside_res: expected %0b, actual none", left_want);
      fail_count++;
    end
    $display("Checked %0d point queries against %0d capsule settings (%0d reported inside).",
             points_sent, settings_used, inside_seen);
    $display("Settings spanned zero and full half heights, tapers both ways and extreme axes.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* point_in_tapered_capsule.f */
rtl/pitc_pkg.sv
rtl/point_in_tapered_capsule.sv
tb/sv/point_in_tapered_capsule_tb.sv
